/* rtl/core/x86se_pkg.sv */
// ----------------------------------------------------------------------------
// x86se_pkg
// shared types, opcode constants and field widths of the x86 subset executor
// ----------------------------------------------------------------------------
package x86se_pkg;

    localparam int WordW    = 64;
    localparam int ProdW    = 2 * WordW;
    localparam int HalfW    = WordW / 2;
    localparam int FlagW    = 4;
    localparam int StatusW  = 2;
    // only registers 0..7 can be named by this subset
    localparam int RegCount = 8;
    localparam int RegIdxW  = $clog2(RegCount);

    localparam int InDataW  = 152;
    localparam int OutDataW = 328;

    // opcode bytes
    localparam logic [7:0] OpRexW    = 8'h48;
    localparam logic [7:0] OpMovRax  = 8'hB8;
    localparam logic [7:0] OpAddImm  = 8'h05;
    localparam logic [7:0] OpMovRbx  = 8'hBB;
    localparam logic [7:0] OpGrp3    = 8'hF7;
    localparam logic [7:0] ModRmMulB = 8'hE3;
    localparam logic [7:0] OpAddRm   = 8'h01;
    localparam logic [7:0] OpPush    = 8'h50;
    localparam logic [7:0] OpPop     = 8'h58;
    localparam logic [7:0] OpCall    = 8'hE8;
    localparam logic [7:0] OpRet     = 8'hC3;
    localparam logic [7:0] OpRowMask = 8'hF8;

    // register numbers
    localparam logic [RegIdxW-1:0] RegRax = 3'd0;
    localparam logic [RegIdxW-1:0] RegRdx = 3'd2;
    localparam logic [RegIdxW-1:0] RegRbx = 3'd3;
    localparam logic [RegIdxW-1:0] RegRsp = 3'd4;

    // flag bit positions
    localparam int FlagCf = 0;
    localparam int FlagZf = 1;
    localparam int FlagSf = 2;
    localparam int FlagOf = 3;

    // status codes
    localparam logic [StatusW-1:0] StExecuted   = 2'd0;
    localparam logic [StatusW-1:0] StBadRexOp   = 2'd1;
    localparam logic [StatusW-1:0] StUnknownOp  = 2'd2;

    localparam logic [1:0] ModReg = 2'b11;
    localparam logic [WordW-1:0] SlotBytes = 64'd8;

    typedef struct packed {
        logic [7:0]       opcode;
        logic [7:0]       second_byte;
        logic [7:0]       third_byte;
        logic [WordW-1:0] immediate;
        logic [WordW-1:0] stack_data;
    } t_instr;

    // everything one instruction changes, as seen by the commit logic
    typedef struct packed {
        logic               is_mul;
        logic [WordW-1:0]   mul_b;
        logic               dst_en;
        logic [RegIdxW-1:0] dst_idx;
        logic [WordW-1:0]   dst_val;
        logic               sp_en;
        logic [WordW-1:0]   sp_val;
        logic               dx_en;
        logic [WordW-1:0]   dx_val;
        logic [WordW-1:0]   ip;
        logic [FlagW-1:0]   flags;
        logic               mem_write;
        logic [WordW-1:0]   mem_address;
        logic [WordW-1:0]   mem_data;
        logic [StatusW-1:0] status;
    } t_exec;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_DONE
    } t_mul_state;

endpackage

/* rtl/core/x86se_mul.sv */
// ----------------------------------------------------------------------------
// x86se_mul
// 64x64 -> 128 unsigned multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module x86se_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [x86se_pkg::WordW-1:0]   i_a,
    input  logic [x86se_pkg::WordW-1:0]   i_b,
    input  logic                          i_ack,
    output logic                          o_done,
    output logic [x86se_pkg::ProdW-1:0]   o_product
);

    x86se_pkg::t_mul_state          r_state, n_state;
    logic [2:0]                     r_step, n_step;
    logic [x86se_pkg::WordW-1:0]    r_a, n_a;
    logic [x86se_pkg::WordW-1:0]    r_b, n_b;
    logic [x86se_pkg::WordW-1:0]    r_pp, n_pp;
    logic [1:0]                     r_pp_idx, n_pp_idx;
    logic [x86se_pkg::ProdW-1:0]    r_acc, n_acc;

    logic [x86se_pkg::HalfW-1:0]    a_half;
    logic [x86se_pkg::HalfW-1:0]    b_half;
    logic [x86se_pkg::WordW-1:0]    pp;
    logic [x86se_pkg::ProdW-1:0]    pp_shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= x86se_pkg::MUL_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_pp     <= n_pp;
        r_pp_idx <= n_pp_idx;
        r_acc    <= n_acc;
    end

    // step bit 1 picks the half of a, bit 0 the half of b
    assign a_half = r_step[1] ? r_a[x86se_pkg::WordW-1:x86se_pkg::HalfW]
                              : r_a[x86se_pkg::HalfW-1:0];
    assign b_half = r_step[0] ? r_b[x86se_pkg::WordW-1:x86se_pkg::HalfW]
                              : r_b[x86se_pkg::HalfW-1:0];
    assign pp     = a_half * b_half;

    always_comb begin
        case (r_pp_idx) inside
            2'd0:       pp_shifted = {{x86se_pkg::WordW{1'b0}}, r_pp};
            2'd1, 2'd2: pp_shifted = {{x86se_pkg::HalfW{1'b0}}, r_pp,
                                      {x86se_pkg::HalfW{1'b0}}};
            default:    pp_shifted = {r_pp, {x86se_pkg::WordW{1'b0}}};
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_a      = r_a;
        n_b      = r_b;
        n_pp     = r_pp;
        n_pp_idx = r_pp_idx;
        n_acc    = r_acc;
        unique case (r_state)
            x86se_pkg::MUL_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_acc   = '0;
                    n_step  = 3'd0;
                    n_state = x86se_pkg::MUL_RUN;
                end
            end
            x86se_pkg::MUL_RUN: begin
                // add the product of the previous step
                if (r_step != 3'd0) begin
                    n_acc = r_acc + pp_shifted;
                end
                if (r_step == 3'd4) begin
                    n_state = x86se_pkg::MUL_DONE;
                end else begin
                    n_pp     = pp;
                    n_pp_idx = r_step[1:0];
                    n_step   = r_step + 3'd1;
                end
            end
            x86se_pkg::MUL_DONE: begin
                if (i_ack) begin
                    n_state = x86se_pkg::MUL_IDLE;
                end
            end
            default: begin
                n_state = x86se_pkg::MUL_IDLE;
            end
        endcase
    end

    assign o_done    = (r_state == x86se_pkg::MUL_DONE);
    assign o_product = r_acc;

endmodule

/* rtl/core/x86se_exec.sv */
// ----------------------------------------------------------------------------
// x86se_exec
// decode and execute of one instruction against the current machine state
// ----------------------------------------------------------------------------
module x86se_exec (
    input  x86se_pkg::t_instr                  i_instr,
    input  logic [x86se_pkg::WordW-1:0]        i_ip,
    input  logic [x86se_pkg::FlagW-1:0]        i_flags,
    input  logic [x86se_pkg::WordW-1:0]        i_rax,
    input  logic [x86se_pkg::WordW-1:0]        i_rbx,
    input  logic [x86se_pkg::WordW-1:0]        i_rsp,
    input  logic [x86se_pkg::WordW-1:0]        i_opa,
    input  logic [x86se_pkg::WordW-1:0]        i_opb,
    input  logic [x86se_pkg::ProdW-1:0]        i_product,
    output x86se_pkg::t_exec                   o_exec
);

    logic [7:0]                    op;
    logic [7:0]                    b2;
    logic                          mod_reg;
    logic [x86se_pkg::WordW-1:0]   add_a;
    logic [x86se_pkg::WordW-1:0]   add_b;
    logic [x86se_pkg::WordW:0]     sum;
    logic [x86se_pkg::FlagW-1:0]   add_flags;
    logic [x86se_pkg::WordW-1:0]   rel;
    logic [x86se_pkg::WordW-1:0]   ret_ip;
    logic [x86se_pkg::WordW-1:0]   sp_dec;
    logic [x86se_pkg::WordW-1:0]   sp_inc;

    assign op      = i_instr.opcode;
    assign b2      = i_instr.second_byte;
    assign mod_reg = (b2[7:6] == x86se_pkg::ModReg);

    // shared adder: r/m + reg for 01, rax + imm32 otherwise
    assign add_a = (op == x86se_pkg::OpAddRm) ? i_opa : i_rax;
    assign add_b = (op == x86se_pkg::OpAddRm) ? i_opb
                                              : {32'd0, i_instr.immediate[31:0]};
    assign sum   = {1'b0, add_a} + {1'b0, add_b};

    always_comb begin
        add_flags                      = '0;
        add_flags[x86se_pkg::FlagCf]   = sum[x86se_pkg::WordW];
        add_flags[x86se_pkg::FlagZf]   = (sum[x86se_pkg::WordW-1:0] == '0);
        add_flags[x86se_pkg::FlagSf]   = sum[x86se_pkg::WordW-1];
        add_flags[x86se_pkg::FlagOf]   = (add_a[63] == add_b[63]) && (add_a[63] != sum[63]);
    end

    assign rel    = {{32{i_instr.immediate[31]}}, i_instr.immediate[31:0]};
    assign ret_ip = i_ip + 64'd5;
    assign sp_dec = i_rsp - x86se_pkg::SlotBytes;
    assign sp_inc = i_rsp + x86se_pkg::SlotBytes;

    always_comb begin
        o_exec        = '0;
        o_exec.ip     = i_ip;
        o_exec.flags  = i_flags;
        o_exec.status = x86se_pkg::StExecuted;
        o_exec.mul_b  = i_opa;
        if (op == x86se_pkg::OpRexW) begin
            if (b2 == x86se_pkg::OpMovRax) begin
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = x86se_pkg::RegRax;
                o_exec.dst_val = i_instr.immediate;
                o_exec.ip      = i_ip + 64'd10;
            end else if (b2 == x86se_pkg::OpMovRbx) begin
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = x86se_pkg::RegRbx;
                o_exec.dst_val = i_instr.immediate;
                o_exec.ip      = i_ip + 64'd10;
            end else if (b2 == x86se_pkg::OpAddImm) begin
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = x86se_pkg::RegRax;
                o_exec.dst_val = sum[x86se_pkg::WordW-1:0];
                o_exec.flags   = add_flags;
                o_exec.ip      = i_ip + 64'd6;
            end else if (b2 == x86se_pkg::OpGrp3 &&
                         i_instr.third_byte == x86se_pkg::ModRmMulB) begin
                // full product into rdx:rax
                o_exec.is_mul  = 1'b1;
                o_exec.mul_b   = i_rbx;
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = x86se_pkg::RegRax;
                o_exec.dst_val = i_product[x86se_pkg::WordW-1:0];
                o_exec.dx_en   = 1'b1;
                o_exec.dx_val  = i_product[x86se_pkg::ProdW-1:x86se_pkg::WordW];
                o_exec.flags[x86se_pkg::FlagCf] = 1'b0;
                o_exec.flags[x86se_pkg::FlagOf] = 1'b0;
                o_exec.ip      = i_ip + 64'd3;
            end else begin
                o_exec.status  = x86se_pkg::StBadRexOp;
            end
        end else if (op == x86se_pkg::OpAddRm) begin
            if (mod_reg) begin
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = b2[x86se_pkg::RegIdxW-1:0];
                o_exec.dst_val = sum[x86se_pkg::WordW-1:0];
                o_exec.flags   = add_flags;
            end
            o_exec.ip = i_ip + 64'd2;
        end else if (op == x86se_pkg::OpGrp3) begin
            if (mod_reg) begin
                o_exec.is_mul  = 1'b1;
                o_exec.dst_en  = 1'b1;
                o_exec.dst_idx = x86se_pkg::RegRax;
                o_exec.dst_val = i_product[x86se_pkg::WordW-1:0];
            end
            o_exec.ip = i_ip + 64'd2;
        end else if ((op & x86se_pkg::OpRowMask) == x86se_pkg::OpPush) begin
            o_exec.sp_en       = 1'b1;
            o_exec.sp_val      = sp_dec;
            o_exec.mem_write   = 1'b1;
            o_exec.mem_address = sp_dec;
            o_exec.mem_data    = i_opa;
            o_exec.ip          = i_ip + 64'd1;
        end else if ((op & x86se_pkg::OpRowMask) == x86se_pkg::OpPop) begin
            // the register write wins over the rsp bump for pop rsp
            o_exec.sp_en   = 1'b1;
            o_exec.sp_val  = sp_inc;
            o_exec.dst_en  = 1'b1;
            o_exec.dst_idx = op[x86se_pkg::RegIdxW-1:0];
            o_exec.dst_val = i_instr.stack_data;
            o_exec.ip      = i_ip + 64'd1;
        end else if (op == x86se_pkg::OpCall) begin
            o_exec.sp_en       = 1'b1;
            o_exec.sp_val      = sp_dec;
            o_exec.mem_write   = 1'b1;
            o_exec.mem_address = sp_dec;
            o_exec.mem_data    = ret_ip;
            o_exec.ip          = i_ip + 64'd5 + rel;
        end else if (op == x86se_pkg::OpRet) begin
            o_exec.sp_en  = 1'b1;
            o_exec.sp_val = sp_inc;
            o_exec.ip     = i_instr.stack_data;
        end else begin
            o_exec.status = x86se_pkg::StUnknownOp;
        end
    end

endmodule

/* rtl/core/x86_subset_instruction_executor_unit.sv */
// ----------------------------------------------------------------------------
// x86_subset_instruction_executor_unit
// executes one pre-decoded instruction of a small 64-bit x86 subset per word
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata fields (lowest bit first)
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | opcode, second_byte, third_byte, immediate, stack_data
//  m_axis   | out       | mem_write, mem_address, mem_data, next_ip,
//           |           | stack_pointer, accumulator, flag_bits, status
//
//  an input word sits in the input register while it is executed and its result
//  lands in the output register: one word per cycle while execution does not hold
//  multiplies (48 f7 e3 and f7 register mode) run through the shared 32x32
//  multiplier: start, four partial products, final add and done
//  a word is accepted while the previous result still waits on m_axis;
//  execution holds while a multiply runs or the output register is full and not taken
//  reset clears registers, instruction pointer, flags and both valids
//
module x86_subset_instruction_executor_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // opcode[7:0], second_byte[15:8], third_byte[23:16],
    // immediate[87:24], stack_data[151:88]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [x86se_pkg::InDataW-1:0]      i_s_axis_tdata,
    // mem_write[0], mem_address[64:1], mem_data[128:65], next_ip[192:129],
    // stack_pointer[256:193], accumulator[320:257], flag_bits[324:321],
    // status[326:325], zero pad[327]
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [x86se_pkg::OutDataW-1:0]     o_m_axis_tdata
);

    // architectural state
    logic [x86se_pkg::WordW-1:0]   r_rf [x86se_pkg::RegCount];
    logic [x86se_pkg::WordW-1:0]   n_rf [x86se_pkg::RegCount];
    logic [x86se_pkg::WordW-1:0]   r_ip;
    logic [x86se_pkg::FlagW-1:0]   r_flags;

    // input register with operands read at accept time
    x86se_pkg::t_instr             r_in;
    logic                          r_in_v;
    logic [x86se_pkg::WordW-1:0]   r_opa;
    logic [x86se_pkg::WordW-1:0]   r_opb;

    // output register
    logic [x86se_pkg::OutDataW-1:0] r_out;
    logic                           r_out_v;

    x86se_pkg::t_instr             in_word;
    x86se_pkg::t_exec              ex;
    logic                          accept;
    logic                          fire;
    logic                          out_free;
    logic                          mul_done;
    logic [x86se_pkg::ProdW-1:0]   mul_product;
    logic [x86se_pkg::RegIdxW-1:0] addr_a;
    logic [x86se_pkg::RegIdxW-1:0] addr_b;

    // unpack the incoming word
    assign in_word.opcode      = i_s_axis_tdata[7:0];
    assign in_word.second_byte = i_s_axis_tdata[15:8];
    assign in_word.third_byte  = i_s_axis_tdata[23:16];
    assign in_word.immediate   = i_s_axis_tdata[87:24];
    assign in_word.stack_data  = i_s_axis_tdata[151:88];

    // handshakes
    assign out_free        = !r_out_v || i_m_axis_tready;
    assign fire            = r_in_v && out_free && (!ex.is_mul || mul_done);
    assign o_s_axis_tready = !r_in_v || fire;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // operand a: r/m for 01 and f7, otherwise the register in the opcode row
    assign addr_a = (in_word.opcode == x86se_pkg::OpAddRm ||
                     in_word.opcode == x86se_pkg::OpGrp3)
                    ? in_word.second_byte[x86se_pkg::RegIdxW-1:0]
                    : in_word.opcode[x86se_pkg::RegIdxW-1:0];
    // operand b: modrm reg field
    assign addr_b = in_word.second_byte[5:3];

    x86se_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_in_v && ex.is_mul),
        .i_a       (r_rf[x86se_pkg::RegRax]),
        .i_b       (ex.mul_b),
        .i_ack     (fire),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    x86se_exec u_exec (
        .i_instr   (r_in),
        .i_ip      (r_ip),
        .i_flags   (r_flags),
        .i_rax     (r_rf[x86se_pkg::RegRax]),
        .i_rbx     (r_rf[x86se_pkg::RegRbx]),
        .i_rsp     (r_rf[x86se_pkg::RegRsp]),
        .i_opa     (r_opa),
        .i_opb     (r_opb),
        .i_product (mul_product),
        .o_exec    (ex)
    );

    // register file update; the destination write has last say
    always_comb begin
        for (int i = 0; i < x86se_pkg::RegCount; i++) begin
            n_rf[i] = r_rf[i];
            if (fire) begin
                if (ex.sp_en && i == int'(x86se_pkg::RegRsp)) begin
                    n_rf[i] = ex.sp_val;
                end
                if (ex.dx_en && i == int'(x86se_pkg::RegRdx)) begin
                    n_rf[i] = ex.dx_val;
                end
                if (ex.dst_en && i == int'(ex.dst_idx)) begin
                    n_rf[i] = ex.dst_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < x86se_pkg::RegCount; i++) begin
                r_rf[i] <= '0;
            end
            r_ip    <= '0;
            r_flags <= '0;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            for (int i = 0; i < x86se_pkg::RegCount; i++) begin
                r_rf[i] <= n_rf[i];
            end
            if (fire) begin
                r_ip    <= ex.ip;
                r_flags <= ex.flags;
            end
            if (accept) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_out_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
        // operands come from the next register values, so a result retiring
        // in the same cycle is seen by the word behind it
        if (accept) begin
            r_in  <= in_word;
            r_opa <= n_rf[addr_a];
            r_opb <= n_rf[addr_b];
        end
        if (fire) begin
            r_out <= {1'b0,
                      ex.status,
                      ex.flags,
                      n_rf[x86se_pkg::RegRax],
                      n_rf[x86se_pkg::RegRsp],
                      ex.ip,
                      ex.mem_data,
                      ex.mem_address,
                      ex.mem_write};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out;

endmodule
